@@ rtl/core/slfd_pkg.sv @@
// Shared types and constants for the sync and length framed deframer.
package slfd_pkg;

  localparam logic [7:0] SYNC_B0 = 8'h0F;
  localparam logic [7:0] SYNC_B1 = 8'hF0;
  localparam logic [7:0] SYNC_B2 = 8'h00;
  localparam logic [7:0] SYNC_B3 = 8'hFF;
  localparam logic [7:0] TAIL_B0 = 8'h0D;
  localparam logic [7:0] TAIL_B1 = 8'h0A;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END_OK  = 2'd1,
    KIND_END_BAD = 2'd2
  } kind_e;

  // One-hot parser phases.
  typedef enum logic [9:0] {
    PH_HUNT0   = 10'b00_0000_0001,
    PH_HUNT1   = 10'b00_0000_0010,
    PH_HUNT2   = 10'b00_0000_0100,
    PH_HUNT3   = 10'b00_0000_1000,
    PH_LEN_HI  = 10'b00_0001_0000,
    PH_LEN_LO  = 10'b00_0010_0000,
    PH_TYPE    = 10'b00_0100_0000,
    PH_PAYLOAD = 10'b00_1000_0000,
    PH_TAIL0   = 10'b01_0000_0000,
    PH_TAIL1   = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_value;
    logic        is_last_byte;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [7:0]  first_payload;
  } result_t;

endpackage

@@ rtl/core/sync_length_frame_deframer.sv @@
// Byte-serial deframer for sync-word, length-prefixed frames with a fixed tail.
//
// The block takes one received byte per input word and hunts for the sync word
// 0F F0 00 FF. After sync it reads a big-endian 16-bit payload length, one type
// byte, that many payload bytes and a two-byte tail that should be 0D 0A. Every
// payload byte leaves as a result word of kind 0 with a last flag on the final
// one. After the second tail byte one frame-end word reports the type, the
// length, the first payload byte (or the first tail byte for an empty payload)
// and the tail check: kind 1 for a good tail, kind 2 for a bad one. Either way
// the parser returns to hunting with the next byte. A byte that breaks a
// partial sync match restarts the hunt, counting as one matched byte if it is
// 0F. The parser state updates at the edge that accepts the byte, and its
// result, if any, lands at that same edge in the output register, or in the
// skid register behind it when the output register is full and stalled, so a
// byte can be accepted on every cycle while the skid register is empty. The skid
// register holds one extra result, so the input only stalls once both are full
// while the output side is stalled; in_stall_o is a plain register output.
module sync_length_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  byte_value_o,
  output logic        is_last_byte_o,
  output logic [7:0]  frame_type_o,
  output logic [15:0] frame_length_o,
  output logic [7:0]  first_payload_o
);
  import slfd_pkg::*;

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [15:0] length_q, length_d;
  logic [15:0] remaining_q, remaining_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  first_q, first_d;
  logic        tail_ok_q, tail_ok_d;

  // Output register and skid register.
  result_t out_q, skid_q, res;
  logic    out_valid_q, skid_valid_q;
  logic    res_valid;
  logic    accept, take;

  assign accept = in_valid_i && !skid_valid_q;
  assign take   = out_valid_q && !out_stall_i;

  // Next state and result for the byte at the input.
  always_comb begin
    phase_d     = phase_q;
    length_d    = length_q;
    remaining_d = remaining_q;
    type_d      = type_q;
    first_d     = first_q;
    tail_ok_d   = tail_ok_q;
    res         = '0;
    res_valid   = 1'b0;
    case (phase_q)
      PH_HUNT0: begin
        phase_d = (rx_byte_i == SYNC_B0) ? PH_HUNT1 : PH_HUNT0;
      end
      PH_HUNT1: begin
        if (rx_byte_i == SYNC_B1) begin
          phase_d = PH_HUNT2;
        end else begin
          phase_d = (rx_byte_i == SYNC_B0) ? PH_HUNT1 : PH_HUNT0;
        end
      end
      PH_HUNT2: begin
        if (rx_byte_i == SYNC_B2) begin
          phase_d = PH_HUNT3;
        end else begin
          phase_d = (rx_byte_i == SYNC_B0) ? PH_HUNT1 : PH_HUNT0;
        end
      end
      PH_HUNT3: begin
        if (rx_byte_i == SYNC_B3) begin
          phase_d = PH_LEN_HI;
        end else begin
          phase_d = (rx_byte_i == SYNC_B0) ? PH_HUNT1 : PH_HUNT0;
        end
      end
      PH_LEN_HI: begin
        length_d = {rx_byte_i, 8'h00};
        phase_d  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_d    = {length_q[15:8], rx_byte_i};
        remaining_d = {length_q[15:8], rx_byte_i};
        phase_d     = PH_TYPE;
      end
      PH_TYPE: begin
        type_d  = rx_byte_i;
        phase_d = (remaining_q != 16'd0) ? PH_PAYLOAD : PH_TAIL0;
      end
      PH_PAYLOAD: begin
        if (remaining_q == length_q) begin
          first_d = rx_byte_i;
        end
        res.kind         = KIND_PAYLOAD;
        res.byte_value   = rx_byte_i;
        res.is_last_byte = (remaining_q == 16'd1);
        res_valid        = 1'b1;
        remaining_d      = remaining_q - 16'd1;
        if (remaining_q == 16'd1) begin
          phase_d = PH_TAIL0;
        end
      end
      PH_TAIL0: begin
        if (length_q == 16'd0) begin
          first_d = rx_byte_i;
        end
        tail_ok_d = (rx_byte_i == TAIL_B0);
        phase_d   = PH_TAIL1;
      end
      PH_TAIL1: begin
        res.kind          = (tail_ok_q && rx_byte_i == TAIL_B1) ? KIND_END_OK : KIND_END_BAD;
        res.frame_type    = type_q;
        res.frame_length  = length_q;
        res.first_payload = first_q;
        res_valid         = 1'b1;
        tail_ok_d         = 1'b0;
        phase_d           = PH_HUNT0;
      end
      default: begin
        phase_d = (rx_byte_i == SYNC_B0) ? PH_HUNT1 : PH_HUNT0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT0;
      length_q    <= '0;
      remaining_q <= '0;
      type_q      <= '0;
      first_q     <= '0;
      tail_ok_q   <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      length_q    <= length_d;
      remaining_q <= remaining_d;
      type_q      <= type_d;
      first_q     <= first_d;
      tail_ok_q   <= tail_ok_d;
    end
  end

  // The skid register is only loaded while the output register is full and
  // stalled; the input stalls while it holds a word, so order is kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || take) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept && res_valid;
        end
      end else if (accept && res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept && res_valid) begin
        out_q <= res;
      end
    end else if (accept && res_valid) begin
      skid_q <= res;
    end
  end

  assign in_stall_o      = skid_valid_q;
  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_q.kind;
  assign byte_value_o    = out_q.byte_value;
  assign is_last_byte_o  = out_q.is_last_byte;
  assign frame_type_o    = out_q.frame_type;
  assign frame_length_o  = out_q.frame_length;
  assign first_payload_o = out_q.first_payload;

endmodule
